### rtl/tbdlp_pkg.sv
package tbdlp_pkg;

  // Width of the change and hold timers; both saturate at all ones
  localparam int TIMER_BITS = 16;
  localparam int CFG_BITS   = 16;
  // Width at which a timer is compared against a tick register
  localparam int CMP_W      = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // Configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] REG_LONG      = 2'd1;
  localparam logic [1:0] REG_A_ENABLE  = 2'd2;
  localparam logic [1:0] REG_B_ENABLE  = 2'd3;

  // Configuration reset values
  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_BITS-1:0] LONG_RESET     = 16'd1500;

  typedef struct packed {
    logic       level_a;
    logic       level_b;
    logic [3:0] clear_mask;
  } tbdlp_in_t;

  typedef struct packed {
    logic a_short_seen;
    logic a_long_seen;
    logic b_short_seen;
    logic b_long_seen;
    logic a_held_now;
    logic b_held_now;
  } tbdlp_out_t;

  // Events raised by one button on one sample tick
  typedef struct packed {
    logic short_ev;
    logic long_ev;
  } tbdlp_evt_t;

  // Increment a timer, stopping at its largest value
  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    logic [TIMER_BITS-1:0] r;
    r = (v == TIMER_MAX) ? TIMER_MAX : v + 1'b1;
    return r;
  endfunction

endpackage

### rtl/tbdlp_button.sv
module tbdlp_button (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          raw,
  input  logic [tbdlp_pkg::CFG_BITS-1:0] debounce_ticks,
  input  logic [tbdlp_pkg::CFG_BITS-1:0] long_press_ticks,
  output tbdlp_pkg::tbdlp_evt_t         evt
);
  import tbdlp_pkg::*;

  logic                  prev_r, prev_nxt;
  logic [TIMER_BITS-1:0] tsc_r, tsc_nxt;
  logic                  deb_r, deb_nxt;
  logic [TIMER_BITS-1:0] hold_r, hold_nxt;
  logic                  press_r, press_nxt;
  logic                  lrep_r, lrep_nxt;
  logic                  settle;

  // Debounce, hold timing and press classification for one tick
  always_comb begin
    prev_nxt     = raw;
    tsc_nxt      = (raw != prev_r) ? '0 : sat_inc(tsc_r);
    hold_nxt     = press_r ? sat_inc(hold_r) : hold_r;
    deb_nxt      = deb_r;
    press_nxt    = press_r;
    lrep_nxt     = lrep_r;
    evt.short_ev = 1'b0;
    evt.long_ev  = 1'b0;

    settle = (CMP_W'(tsc_nxt) > CMP_W'(debounce_ticks)) && (deb_r != raw);
    if (settle) begin
      deb_nxt = raw;
      if (!raw) begin
        hold_nxt  = '0;
        press_nxt = 1'b1;
        lrep_nxt  = 1'b0;
      end else if (press_r && !lrep_r) begin
        evt.short_ev = 1'b1;
        press_nxt    = 1'b0;
      end
    end

    if (!deb_nxt && press_nxt && !lrep_nxt &&
        (CMP_W'(hold_nxt) >= CMP_W'(long_press_ticks))) begin
      evt.long_ev = 1'b1;
      lrep_nxt    = 1'b1;
    end
  end

  // Advance state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b1;
      tsc_r   <= '0;
      deb_r   <= 1'b1;
      hold_r  <= '0;
      press_r <= 1'b0;
      lrep_r  <= 1'b0;
    end else if (step) begin
      prev_r  <= prev_nxt;
      tsc_r   <= tsc_nxt;
      deb_r   <= deb_nxt;
      hold_r  <= hold_nxt;
      press_r <= press_nxt;
      lrep_r  <= lrep_nxt;
    end
  end

endmodule

### rtl/two_button_debounce_long_press_core.sv
// Latency: a result is valid in the cycle after its input transfer.
// Throughput: one sample per cycle while out_ready is high; a single result
// register parts the two sides, so a new sample is taken as the old result leaves.
// Reset (rst_n low, synchronous) releases both buttons, clears timers and flags,
// empties the result register and loads debounce 50 and long press 1500 ticks.
module two_button_debounce_long_press_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tbdlp_pkg::tbdlp_in_t           in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tbdlp_pkg::tbdlp_out_t          out_data,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [tbdlp_pkg::CFG_BITS-1:0] cfg_wdata
);
  import tbdlp_pkg::*;

  logic [CFG_BITS-1:0] deb_ticks_r;
  logic [CFG_BITS-1:0] long_ticks_r;
  logic                a_en_r;
  logic                b_en_r;
  logic [3:0]          flags_r, flags_nxt, flags_rep;
  logic                out_valid_r;
  tbdlp_out_t          out_data_r, out_data_nxt;
  logic                step;
  logic                raw_a, raw_b;
  tbdlp_evt_t          evt_a, evt_b;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_ticks_r  <= DEBOUNCE_RESET;
      long_ticks_r <= LONG_RESET;
      a_en_r       <= 1'b1;
      b_en_r       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: deb_ticks_r  <= cfg_wdata;
        REG_LONG:     long_ticks_r <= cfg_wdata;
        REG_A_ENABLE: a_en_r       <= cfg_wdata[0];
        REG_B_ENABLE: b_en_r       <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  // Take a sample when the result register is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  assign raw_a = a_en_r ? in_data.level_a : 1'b1;
  assign raw_b = b_en_r ? in_data.level_b : 1'b1;

  tbdlp_button u_btn_a (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .raw              (raw_a),
    .debounce_ticks   (deb_ticks_r),
    .long_press_ticks (long_ticks_r),
    .evt              (evt_a)
  );

  tbdlp_button u_btn_b (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .raw              (raw_b),
    .debounce_ticks   (deb_ticks_r),
    .long_press_ticks (long_ticks_r),
    .evt              (evt_b)
  );

  // Report the sticky flags, then drop those named in the clear mask
  always_comb begin
    flags_rep = flags_r | {evt_b.long_ev, evt_b.short_ev, evt_a.long_ev, evt_a.short_ev};
    flags_nxt = flags_rep & ~in_data.clear_mask;

    out_data_nxt.a_short_seen = flags_rep[0];
    out_data_nxt.a_long_seen  = flags_rep[1];
    out_data_nxt.b_short_seen = flags_rep[2];
    out_data_nxt.b_long_seen  = flags_rep[3];
    out_data_nxt.a_held_now   = a_en_r && !in_data.level_a;
    out_data_nxt.b_held_now   = b_en_r && !in_data.level_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (step) begin
      flags_r <= flags_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A transfer in always leaves a result waiting
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("input transfer did not produce a result");

  // Sticky flags move only on an input transfer
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(flags_r))
    else $error("flags changed without an input transfer");

  // A flag already held before the tick is still reported (checked for A short and B long)
  a_flags_cover_state: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> ((out_data_r.a_short_seen || !$past(flags_r[0])) &&
              (out_data_r.b_long_seen  || !$past(flags_r[3]))))
    else $error("held flag missing from report");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule
